@@ hw/rtl/hkf_pkg.sv @@
// ----------------------------------------------------------------------------
// hkf_pkg
// Shared constants and types of the hotkey key event filter.
// ----------------------------------------------------------------------------
package hkf_pkg;

  // Number of hotkey entries that take part in matching, and slots stored.
  localparam int HOTKEY_ENTRIES = 6;
  localparam int ENTRY_SLOTS    = 6;

  // Key codes covered by the owed-release map.
  localparam int KEY_CODES  = 256;
  localparam int MAP_ADDR_W = (KEY_CODES > 1) ? $clog2(KEY_CODES) : 1;

  // Field widths.
  localparam int CODE_W     = 9;
  localparam int KEY_W      = 8;
  localparam int ID_W       = 8;
  localparam int ENTRY_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_FIRST   = 3'd1;

  // Bit positions inside a hotkey entry.
  localparam int ENT_VALID_BIT = 0;
  localparam int ENT_SHIFT_BIT = 1;
  localparam int ENT_ALT_BIT   = 2;
  localparam int ENT_CTRL_BIT  = 3;
  localparam int ENT_KEY_LSB   = 4;
  localparam int ENT_ID_LSB    = 12;

  typedef logic [ENTRY_W-1:0] entry_t;

  // Outcome of the priority match against the hotkey table.
  typedef struct packed {
    logic            hit;
    logic [ID_W-1:0] id;
  } match_t;

  // Event word held in the map lookup stage.
  typedef struct packed {
    logic                  live;
    logic                  key_down;
    logic [MAP_ADDR_W-1:0] addr;
    match_t                match;
  } stage_t;

endpackage

@@ hw/rtl/hkf_event_if.sv @@
// ----------------------------------------------------------------------------
// hkf_event_if
// Valid/ready channel that carries one key event word.
// ----------------------------------------------------------------------------
interface hkf_event_if
  import hkf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              hook_action;
  logic              key_down;
  logic              injected;
  logic [CODE_W-1:0] key_code;
  logic              ctrl_held;
  logic              alt_held;
  logic              shift_held;

  modport source (
    output valid, hook_action, key_down, injected, key_code,
           ctrl_held, alt_held, shift_held,
    input  ready
  );

  modport sink (
    input  valid, hook_action, key_down, injected, key_code,
           ctrl_held, alt_held, shift_held,
    output ready
  );
endinterface

@@ hw/rtl/hkf_result_if.sv @@
// ----------------------------------------------------------------------------
// hkf_result_if
// Valid/ready channel that carries one filter decision word.
// ----------------------------------------------------------------------------
interface hkf_result_if
  import hkf_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            block;
  logic            fired;
  logic [ID_W-1:0] hotkey_id;

  modport source (
    output valid, block, fired, hotkey_id,
    input  ready
  );

  modport sink (
    input  valid, block, fired, hotkey_id,
    output ready
  );
endinterface

@@ hw/rtl/hotkey_key_event_filter_top.sv @@
// ----------------------------------------------------------------------------
// hotkey_key_event_filter_top
// Key event filter: blocks hotkey presses and their owed releases and
// raises a notification on the first press of a matched hotkey.
//
//   Channel   Dir   Handshake     Word
//   evt       in    valid/ready   hook_action, key_down, injected, key_code,
//                                 ctrl_held, alt_held, shift_held
//   res       out   valid/ready   block, fired, hotkey_id
//   cfg_*     in    write enable  cfg_index, cfg_data
//
// One event word per cycle, sustained while results are taken and the map is
// not clearing. A result is presented after its event is taken: the map memory
// is read at the accepting edge, and the decision is written back into the map
// and the output register when the lookup stage advances. After reset the map
// memory is cleared one entry per cycle, with evt.ready low. A stalled result
// holds the lookup stage, and evt.ready also drops while that stage is full and
// cannot advance.
module hotkey_key_event_filter_top
  import hkf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  hkf_event_if.sink             evt,
  hkf_result_if.source          res,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic   filter_enable;
  match_t match;
  logic   clearing;
  logic   map_rd_data;

  logic   s1_valid;
  stage_t s1;
  logic   s1_fwd;
  logic   s1_fwd_val;

  logic   s1_adv;
  logic   accept;
  logic   in_live;
  logic   owed;
  logic   owed_next;
  logic   blk_next;
  logic   fired_next;
  logic [ID_W-1:0] id_next;
  logic   map_we;
  logic [MAP_ADDR_W-1:0] in_addr;

  hkf_cfg_match u_match (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .key_code      (evt.key_code),
    .ctrl_held     (evt.ctrl_held),
    .alt_held      (evt.alt_held),
    .shift_held    (evt.shift_held),
    .filter_enable (filter_enable),
    .match         (match)
  );

  assign in_addr = evt.key_code[MAP_ADDR_W-1:0];
  assign in_live = evt.hook_action && !evt.injected &&
                   (evt.key_code < CODE_W'(KEY_CODES));

  assign s1_adv    = s1_valid && (!res.valid || res.ready);
  assign evt.ready = !clearing && (!s1_valid || s1_adv);
  assign accept    = evt.valid && evt.ready;
  assign map_we    = s1_adv && s1.live;

  hkf_owed_mem u_map (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (in_addr),
    .rd_data  (map_rd_data),
    .wr_en    (map_we),
    .wr_addr  (s1.addr),
    .wr_data  (owed_next),
    .clearing (clearing)
  );

  // The memory read misses a write-back at the same edge, so that bit is
  // carried along beside the read.
  assign owed = s1_fwd ? s1_fwd_val : map_rd_data;

  always_comb begin
    owed_next  = owed;
    blk_next   = 1'b0;
    fired_next = 1'b0;
    id_next    = '0;
    if (s1.live) begin
      if (!s1.key_down) begin
        blk_next  = owed;
        owed_next = 1'b0;
      end else if (filter_enable && s1.match.hit) begin
        blk_next   = 1'b1;
        fired_next = !owed;
        id_next    = owed ? '0 : s1.match.id;
        owed_next  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.live     <= in_live;
      s1.key_down <= evt.key_down;
      s1.addr     <= in_addr;
      s1.match    <= match;
      s1_fwd      <= map_we && (s1.addr == in_addr);
      s1_fwd_val  <= owed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_adv) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res.block     <= blk_next;
      res.fired     <= fired_next;
      res.hotkey_id <= id_next;
    end
  end

endmodule

@@ hw/rtl/hkf_cfg_match.sv @@
// ----------------------------------------------------------------------------
// hkf_cfg_match
// Configuration registers and first-match compare against the hotkey table.
// ----------------------------------------------------------------------------
module hkf_cfg_match
  import hkf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CODE_W-1:0]     key_code,
  input  logic                  ctrl_held,
  input  logic                  alt_held,
  input  logic                  shift_held,
  output logic                  filter_enable,
  output match_t                match
);

  entry_t entry [ENTRY_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      for (int i = 0; i < ENTRY_SLOTS; i++) begin
        entry[i] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == REG_FILTER_ENABLE) begin
        filter_enable <= cfg_data[0];
      end
      for (int i = 0; i < ENTRY_SLOTS; i++) begin
        if (cfg_index == REG_ENTRY_FIRST + CFG_IDX_W'(i)) begin
          entry[i] <= cfg_data[ENTRY_W-1:0];
        end
      end
    end
  end

  // Walk from the highest entry down so the lowest matching index wins.
  always_comb begin
    match = '0;
    for (int i = HOTKEY_ENTRIES - 1; i >= 0; i--) begin
      if (entry[i][ENT_VALID_BIT] &&
          entry[i][ENT_SHIFT_BIT] == shift_held &&
          entry[i][ENT_ALT_BIT] == alt_held &&
          entry[i][ENT_CTRL_BIT] == ctrl_held &&
          CODE_W'(entry[i][ENT_KEY_LSB +: KEY_W]) == key_code) begin
        match.hit = 1'b1;
        match.id  = entry[i][ENT_ID_LSB +: ID_W];
      end
    end
  end

endmodule

@@ hw/rtl/hkf_owed_mem.sv @@
// ----------------------------------------------------------------------------
// hkf_owed_mem
// Owed-release map: one bit per key code in a synchronous memory, with a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module hkf_owed_mem
  import hkf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [MAP_ADDR_W-1:0] rd_addr,
  output logic                  rd_data,
  input  logic                  wr_en,
  input  logic [MAP_ADDR_W-1:0] wr_addr,
  input  logic                  wr_data,
  output logic                  clearing
);

  logic                  mem [KEY_CODES];
  logic [MAP_ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == MAP_ADDR_W'(KEY_CODES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // A read at the same edge as a write to the same entry returns the old bit.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
